// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the plane/volume classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define PVC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pvc: assertion failed");
// Checked on every clock edge, reset included.
`define PVC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pvc: reset assertion failed");
`else
`define PVC_ASSERT(lbl, prop)
`define PVC_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/core/pvc_pkg.sv =====
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types and constants of the plane/volume classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pvc_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic OP_BOX    = 1'b0;
    localparam logic OP_SPHERE = 1'b1;

    localparam logic [1:0] REL_FRONT = 2'd0;
    localparam logic [1:0] REL_BACK  = 2'd1;
    localparam logic [1:0] REL_INTER = 2'd2;

    localparam logic [1:0] REG_NORMAL_X = 2'd0;
    localparam logic [1:0] REG_NORMAL_Y = 2'd1;
    localparam logic [1:0] REG_NORMAL_Z = 2'd2;
    localparam logic [1:0] REG_OFFSET   = 2'd3;

    // Stage enables of the dot-product pipeline
    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
    } pvc_pipe_en_t;

endpackage

`default_nettype wire

// ===== rtl/core/plane_volume_classify.sv =====
// ----------------------------------------------------------------------------
// plane_volume_classify
// Classifies a box or sphere against a plane held in APB registers:
// front, back or intersecting.
// ----------------------------------------------------------------------------
// Usage:
//   Plane normal and offset are written over the APB port (normal_x at 0,
//   normal_y, normal_z, plane_offset at following words); write only with
//   no item in flight. pready is tied high.
//   Input channel (in_valid/in_ready) carries one volume per transfer;
//   opcode selects box or sphere. Output channel (out_valid/out_ready)
//   returns one relation per transfer, in order.
//   Path from input transfer to out_valid runs through five
//   register stages (select, partial products, products, sum, compare).
//   Throughput: one item per cycle while the output is not stalled,
//   set by the fully pipelined multiply-add datapath.
//   Stalls: each stage holds its item while the one after it is full and
//   blocked, so bubbles close up and in_ready only drops once all five
//   stages are occupied behind a stalled output.
//   Reset clears all valid bits and the plane registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module plane_volume_classify
    import pvc_pkg::*;
#(
    parameter int COORD_BITS = 32,
    localparam int DATA_W = (COORD_BITS > 32) ? 64 : 32,
    localparam int ADDR_W = (COORD_BITS > 32) ? 5 : 4
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ADDR_W-1:0]            paddr,
    input  wire logic [DATA_W-1:0]            pwdata,
    output logic      [DATA_W-1:0]            prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         opcode,
    input  wire logic signed [COORD_BITS-1:0] box_min_x,
    input  wire logic signed [COORD_BITS-1:0] box_min_y,
    input  wire logic signed [COORD_BITS-1:0] box_min_z,
    input  wire logic signed [COORD_BITS-1:0] box_max_x,
    input  wire logic signed [COORD_BITS-1:0] box_max_y,
    input  wire logic signed [COORD_BITS-1:0] box_max_z,
    input  wire logic signed [COORD_BITS-1:0] center_x,
    input  wire logic signed [COORD_BITS-1:0] center_y,
    input  wire logic signed [COORD_BITS-1:0] center_z,
    input  wire logic [COORD_BITS-2:0]        sphere_radius,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        relation
);

    localparam int SUM_W = 2 * COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] normal_x, normal_y, normal_z, plane_offset;

    // select stage
    logic signed [COORD_BITS-1:0] near_x_next, near_y_next, near_z_next;
    logic signed [COORD_BITS-1:0] far_x_next, far_y_next, far_z_next;
    logic signed [COORD_BITS-1:0] near_x_reg, near_y_reg, near_z_reg;
    logic signed [COORD_BITS-1:0] far_x_reg, far_y_reg, far_z_reg;

    // side data travelling with the dot-product stages
    logic                  op_s_reg, op_a_reg, op_b_reg, op_c_reg;
    logic [COORD_BITS-2:0] rad_s_reg, rad_a_reg, rad_b_reg, rad_c_reg;

    logic v_s_reg, v_a_reg, v_b_reg, v_c_reg, out_valid_reg;
    logic en_s, en_d;
    pvc_pipe_en_t pipe_en;

    logic signed [SUM_W-1:0] dist_near, dist_far, rad_al;
    logic signed [SUM_W-1:0] front_val, back_val;
    logic                    is_front, is_back;
    logic [1:0]              relation_next, relation_reg;

    pvc_cfg #(
        .COORD_BITS (COORD_BITS),
        .DATA_W     (DATA_W),
        .ADDR_W     (ADDR_W)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .plane_offset (plane_offset)
    );

    assign pready = 1'b1;

    // stage enables: a stage moves when empty or when the next one moves
    assign en_d         = !out_valid_reg || out_ready;
    assign pipe_en.en_c = !v_c_reg || en_d;
    assign pipe_en.en_b = !v_b_reg || pipe_en.en_c;
    assign pipe_en.en_a = !v_a_reg || pipe_en.en_b;
    assign en_s         = !v_s_reg || pipe_en.en_a;
    assign in_ready     = en_s;

    // near corner takes min where the normal is non-negative
    always_comb
    begin
        if (opcode == OP_SPHERE)
        begin
            near_x_next = center_x;
            near_y_next = center_y;
            near_z_next = center_z;
            far_x_next  = center_x;
            far_y_next  = center_y;
            far_z_next  = center_z;
        end
        else
        begin
            near_x_next = normal_x[COORD_BITS-1] ? box_max_x : box_min_x;
            near_y_next = normal_y[COORD_BITS-1] ? box_max_y : box_min_y;
            near_z_next = normal_z[COORD_BITS-1] ? box_max_z : box_min_z;
            far_x_next  = normal_x[COORD_BITS-1] ? box_min_x : box_max_x;
            far_y_next  = normal_y[COORD_BITS-1] ? box_min_y : box_max_y;
            far_z_next  = normal_z[COORD_BITS-1] ? box_min_z : box_max_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s_reg       <= 1'b0;
            v_a_reg       <= 1'b0;
            v_b_reg       <= 1'b0;
            v_c_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_s)
                v_s_reg <= in_valid;
            if (pipe_en.en_a)
                v_a_reg <= v_s_reg;
            if (pipe_en.en_b)
                v_b_reg <= v_a_reg;
            if (pipe_en.en_c)
                v_c_reg <= v_b_reg;
            if (en_d)
                out_valid_reg <= v_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s)
        begin
            near_x_reg <= near_x_next;
            near_y_reg <= near_y_next;
            near_z_reg <= near_z_next;
            far_x_reg  <= far_x_next;
            far_y_reg  <= far_y_next;
            far_z_reg  <= far_z_next;
            op_s_reg   <= opcode;
            rad_s_reg  <= sphere_radius;
        end
        if (pipe_en.en_a)
        begin
            op_a_reg  <= op_s_reg;
            rad_a_reg <= rad_s_reg;
        end
        if (pipe_en.en_b)
        begin
            op_b_reg  <= op_a_reg;
            rad_b_reg <= rad_a_reg;
        end
        if (pipe_en.en_c)
        begin
            op_c_reg  <= op_b_reg;
            rad_c_reg <= rad_b_reg;
        end
        if (en_d)
            relation_reg <= relation_next;
    end

    pvc_dot #(
        .COORD_BITS (COORD_BITS)
    ) u_dot_near (
        .clk          (clk),
        .pipe_en      (pipe_en),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .plane_offset (plane_offset),
        .pt_x         (near_x_reg),
        .pt_y         (near_y_reg),
        .pt_z         (near_z_reg),
        .signed_dist  (dist_near)
    );

    pvc_dot #(
        .COORD_BITS (COORD_BITS)
    ) u_dot_far (
        .clk          (clk),
        .pipe_en      (pipe_en),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .plane_offset (plane_offset),
        .pt_x         (far_x_reg),
        .pt_y         (far_y_reg),
        .pt_z         (far_z_reg),
        .signed_dist  (dist_far)
    );

    // radius aligned to Q35.32, the scale of the sum
    assign rad_al = SUM_W'($signed({1'b0, rad_c_reg})) <<< FRAC_BITS;

    always_comb
    begin
        if (op_c_reg == OP_SPHERE)
        begin
            front_val = dist_near - rad_al;
            back_val  = dist_near + rad_al;
        end
        else
        begin
            front_val = dist_near;
            back_val  = dist_far;
        end
        is_front = !front_val[SUM_W-1] && (|front_val);
        is_back  = back_val[SUM_W-1];
        if (is_front)
            relation_next = REL_FRONT;
        else if (is_back)
            relation_next = REL_BACK;
        else
            relation_next = REL_INTER;
    end

    assign out_valid = out_valid_reg;
    assign relation  = relation_reg;

    `PVC_ASSERT(a_stall_from_output, !in_ready |-> out_valid_reg && !out_ready)
    `PVC_ASSERT(a_sum_stage_holds, v_c_reg && !en_d |=> v_c_reg && out_valid_reg)
    `PVC_ASSERT_RST(a_reset_empty, $past(!rst_n) && !rst_n |-> !out_valid_reg && !v_c_reg)

endmodule

`default_nettype wire

// ===== rtl/core/pvc_cfg.sv =====
// ----------------------------------------------------------------------------
// pvc_cfg
// APB register file holding the plane normal and offset.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_cfg
    import pvc_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int DATA_W     = 32,
    parameter int ADDR_W     = 4
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ADDR_W-1:0]            paddr,
    input  wire logic [DATA_W-1:0]            pwdata,
    output logic      [DATA_W-1:0]            prdata,
    output logic signed [COORD_BITS-1:0]      normal_x,
    output logic signed [COORD_BITS-1:0]      normal_y,
    output logic signed [COORD_BITS-1:0]      normal_z,
    output logic signed [COORD_BITS-1:0]      plane_offset
);

    localparam int ALIGN = ADDR_W - 2;

    logic [1:0]            idx;
    logic                  wr_en;
    logic [COORD_BITS-1:0] nx_reg, ny_reg, nz_reg, off_reg;
    logic [COORD_BITS-1:0] rd_val;

    assign idx   = paddr[ADDR_W-1:ALIGN];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg  <= '0;
            ny_reg  <= '0;
            nz_reg  <= '0;
            off_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_NORMAL_X: nx_reg  <= pwdata[COORD_BITS-1:0];
                REG_NORMAL_Y: ny_reg  <= pwdata[COORD_BITS-1:0];
                REG_NORMAL_Z: nz_reg  <= pwdata[COORD_BITS-1:0];
                REG_OFFSET:   off_reg <= pwdata[COORD_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_NORMAL_X: rd_val = nx_reg;
            REG_NORMAL_Y: rd_val = ny_reg;
            REG_NORMAL_Z: rd_val = nz_reg;
            REG_OFFSET:   rd_val = off_reg;
            default:      rd_val = '0;
        endcase
    end

    assign prdata       = DATA_W'(rd_val);
    assign normal_x     = $signed(nx_reg);
    assign normal_y     = $signed(ny_reg);
    assign normal_z     = $signed(nz_reg);
    assign plane_offset = $signed(off_reg);

endmodule

`default_nettype wire

// ===== rtl/core/pvc_dot.sv =====
// ----------------------------------------------------------------------------
// pvc_dot
// Three-stage exact signed distance n.p + d: split partial products,
// full products, then the sum in a widened accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_dot
    import pvc_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  wire logic                          clk,
    input  wire pvc_pipe_en_t                  pipe_en,
    input  wire logic signed [COORD_BITS-1:0]  normal_x,
    input  wire logic signed [COORD_BITS-1:0]  normal_y,
    input  wire logic signed [COORD_BITS-1:0]  normal_z,
    input  wire logic signed [COORD_BITS-1:0]  plane_offset,
    input  wire logic signed [COORD_BITS-1:0]  pt_x,
    input  wire logic signed [COORD_BITS-1:0]  pt_y,
    input  wire logic signed [COORD_BITS-1:0]  pt_z,
    output logic signed [2*COORD_BITS+2:0]     signed_dist
);

    localparam int LO_W  = COORD_BITS / 2;
    localparam int HI_W  = COORD_BITS - LO_W;
    localparam int PLO_W = COORD_BITS + LO_W + 1;
    localparam int PHI_W = COORD_BITS + HI_W;
    localparam int P_W   = 2 * COORD_BITS;
    localparam int SUM_W = 2 * COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] nrm [3];
    logic signed [COORD_BITS-1:0] pt  [3];

    logic signed [PLO_W-1:0] plo_next [3];
    logic signed [PHI_W-1:0] phi_next [3];
    logic signed [PLO_W-1:0] plo_reg  [3];
    logic signed [PHI_W-1:0] phi_reg  [3];
    logic signed [P_W-1:0]   prod_next [3];
    logic signed [P_W-1:0]   prod_reg  [3];
    logic signed [COORD_BITS-1:0] off_a_reg, off_b_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;

    assign nrm[0] = normal_x;
    assign nrm[1] = normal_y;
    assign nrm[2] = normal_z;
    assign pt[0]  = pt_x;
    assign pt[1]  = pt_y;
    assign pt[2]  = pt_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            plo_next[i] = PLO_W'(nrm[i]) * PLO_W'($signed({1'b0, pt[i][LO_W-1:0]}));
            phi_next[i] = PHI_W'(nrm[i]) * PHI_W'($signed(pt[i][COORD_BITS-1:LO_W]));
            prod_next[i] = (P_W'(phi_reg[i]) <<< LO_W) + P_W'(plo_reg[i]);
        end
        sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
                 + (SUM_W'(off_b_reg) <<< FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en.en_a)
        begin
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            off_a_reg <= plane_offset;
        end
        if (pipe_en.en_b)
        begin
            prod_reg  <= prod_next;
            off_b_reg <= off_a_reg;
        end
        if (pipe_en.en_c)
        begin
            sum_reg <= sum_next;
        end
    end

    assign signed_dist = sum_reg;

endmodule

`default_nettype wire
